/* rtl/prf_pkg.sv */
package prf_pkg;

  localparam int MAX_NODES = 64;
  localparam int ADDR_W    = $clog2(MAX_NODES);
  localparam int LABEL_W   = 7;
  localparam int DEG_W     = 7;
  localparam int COUNT_W   = 6;
  localparam int DATA_W    = 32;
  localparam int PADDR_W   = 3;

  localparam logic [0:0]         REG_NODE_COUNT   = 1'b0;
  localparam logic [LABEL_W-1:0] NODE_COUNT_RESET = LABEL_W'(64);

  typedef logic [LABEL_W-1:0] label_t;

  typedef struct packed {
    logic [DEG_W-1:0] degree;
    label_t           nbr_xor;
  } entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
    logic              clear;
  } store_req_t;

  typedef enum logic {
    ALU_INC,
    ALU_DEC
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_RD,
    ST_A_WR,
    ST_B_RD,
    ST_B_WR,
    ST_EDGE_END,
    ST_SCAN_RD,
    ST_SCAN_CK,
    ST_LEAF_RD,
    ST_LEAF_CK,
    ST_NB_RD,
    ST_NB_WR,
    ST_NEXT,
    ST_DONE
  } state_t;

  function automatic logic [ADDR_W-1:0] label_index(label_t lab);
    label_t idx;
    idx = lab - LABEL_W'(1);
    return idx[ADDR_W-1:0];
  endfunction

  function automatic logic in_store(label_t lab);
    return (lab != '0) && (lab <= LABEL_W'(MAX_NODES));
  endfunction

endpackage

/* rtl/prf_ram.sv */
module prf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/prf_store.sv */
module prf_store (
  input  logic                clk,
  input  logic                rst,
  input  prf_pkg::store_req_t req,
  output prf_pkg::entry_t     rd_data
);

  logic [prf_pkg::MAX_NODES-1:0]    entry_valid;
  logic                             valid_q;
  logic [$bits(prf_pkg::entry_t)-1:0] ram_rdata;

  prf_ram #(
    .WIDTH ($bits(prf_pkg::entry_t)),
    .DEPTH (prf_pkg::MAX_NODES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (req.wr_en),
    .wr_addr (req.wr_addr),
    .wr_data (req.wr_data),
    .rd_en   (req.rd_en),
    .rd_addr (req.rd_addr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      entry_valid <= '0;
    end else if (req.wr_en) begin
      entry_valid[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      valid_q <= entry_valid[req.rd_addr];
    end
  end

  assign rd_data = valid_q ? prf_pkg::entry_t'(ram_rdata) : '0;

  a_no_rw_same_addr: assert property (@(posedge clk) disable iff (rst)
    !(req.wr_en && req.rd_en && (req.wr_addr == req.rd_addr)))
    else $error("store read and write hit the same entry");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    req.clear |=> (entry_valid == '0))
    else $error("store not empty after clear");

endmodule

/* rtl/prf_alu.sv */
module prf_alu (
  input  prf_pkg::alu_op_t op,
  input  prf_pkg::entry_t  cur,
  input  prf_pkg::label_t  other,
  output prf_pkg::entry_t  result
);

  always_comb begin
    result.nbr_xor = cur.nbr_xor ^ other;
    case (op)
      prf_pkg::ALU_INC: result.degree = cur.degree + prf_pkg::DEG_W'(1);
      prf_pkg::ALU_DEC: result.degree = cur.degree - prf_pkg::DEG_W'(1);
      default:          result.degree = cur.degree;
    endcase
  end

endmodule

/* rtl/tree_to_prufer_encoder_unit.sv */
// Prufer encoder for labelled trees. Write node_count (register 0) while idle, then send the
// edges one request each; the edge with last_edge set starts encoding and node_count - 2
// codes follow (node_count capped at 64), the final one flagged by last_code (nothing for
// node_count of 2 or less). Degree and neighbour-XOR of every node live in one store with
// one access a cycle, so each edge reads and writes back both endpoints, with no write for
// an endpoint outside the store. Each code reads the leaf, loads the code into the output
// register once it is free, then reads and writes back the neighbour; the leaf scan reads
// the degree of each node it passes. No new edge is taken until the last code is loaded,
// and a clear empties the store after each sequence; it needs no clearing pass after reset.
module tree_to_prufer_encoder_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [prf_pkg::PADDR_W-1:0]   paddr,
  input  logic [prf_pkg::DATA_W-1:0]    pwdata,
  output logic [prf_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [prf_pkg::LABEL_W-1:0]   end_a,
  input  logic [prf_pkg::LABEL_W-1:0]   end_b,
  input  logic                          last_edge,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [prf_pkg::LABEL_W-1:0]   code_node,
  output logic                          last_code
);

  prf_pkg::state_t     state;
  prf_pkg::state_t     state_next;
  prf_pkg::label_t     node_count;
  prf_pkg::label_t     edge_a;
  prf_pkg::label_t     edge_b;
  logic                edge_last;
  prf_pkg::label_t     scan_pointer;
  prf_pkg::label_t     current_leaf;
  logic [prf_pkg::COUNT_W-1:0] emitted_count;
  prf_pkg::label_t     nb_label;
  logic                nb_leaf;

  prf_pkg::label_t     eff_n;
  prf_pkg::label_t     total;
  logic                done_all;
  logic                leaf_in;
  logic                nb_in;
  prf_pkg::label_t     leaf_nb;
  logic                slot_free;
  logic                out_load;
  logic                cfg_write;

  prf_pkg::store_req_t req;
  prf_pkg::entry_t     rd_data;
  prf_pkg::alu_op_t    alu_op;
  prf_pkg::entry_t     alu_cur;
  prf_pkg::label_t     alu_other;
  prf_pkg::entry_t     alu_res;

  prf_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data)
  );

  prf_alu u_alu (
    .op     (alu_op),
    .cur    (alu_cur),
    .other  (alu_other),
    .result (alu_res)
  );

  assign eff_n     = (node_count > prf_pkg::LABEL_W'(prf_pkg::MAX_NODES))
                   ? prf_pkg::LABEL_W'(prf_pkg::MAX_NODES) : node_count;
  assign total     = eff_n - prf_pkg::LABEL_W'(2);
  assign done_all  = ({1'b0, emitted_count} == total);
  assign leaf_in   = (current_leaf != '0) && (current_leaf <= eff_n);
  assign nb_in     = (nb_label != '0) && (nb_label <= eff_n);
  assign leaf_nb   = leaf_in ? rd_data.nbr_xor : '0;
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == prf_pkg::ST_IDLE);

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == prf_pkg::REG_NODE_COUNT)
                   ? prf_pkg::DATA_W'(node_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= prf_pkg::NODE_COUNT_RESET;
    end else if (cfg_write && (paddr[2] == prf_pkg::REG_NODE_COUNT)) begin
      node_count <= pwdata[prf_pkg::LABEL_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      prf_pkg::ST_IDLE:     if (in_valid) state_next = prf_pkg::ST_A_RD;
      prf_pkg::ST_A_RD:     state_next = prf_pkg::in_store(edge_a) ? prf_pkg::ST_A_WR
                                                                   : prf_pkg::ST_B_RD;
      prf_pkg::ST_A_WR:     state_next = prf_pkg::ST_B_RD;
      prf_pkg::ST_B_RD:     state_next = prf_pkg::in_store(edge_b) ? prf_pkg::ST_B_WR
                                                                   : prf_pkg::ST_EDGE_END;
      prf_pkg::ST_B_WR:     state_next = prf_pkg::ST_EDGE_END;
      prf_pkg::ST_EDGE_END: begin
        if (!edge_last) begin
          state_next = prf_pkg::ST_IDLE;
        end else if (eff_n > prf_pkg::LABEL_W'(2)) begin
          state_next = prf_pkg::ST_SCAN_RD;
        end else begin
          state_next = prf_pkg::ST_DONE;
        end
      end
      prf_pkg::ST_SCAN_RD:  state_next = (scan_pointer > eff_n) ? prf_pkg::ST_LEAF_RD
                                                                : prf_pkg::ST_SCAN_CK;
      prf_pkg::ST_SCAN_CK:  state_next = (rd_data.degree == prf_pkg::DEG_W'(1))
                                       ? prf_pkg::ST_LEAF_RD : prf_pkg::ST_SCAN_RD;
      prf_pkg::ST_LEAF_RD:  state_next = prf_pkg::ST_LEAF_CK;
      prf_pkg::ST_LEAF_CK:  if (slot_free) state_next = prf_pkg::ST_NB_RD;
      prf_pkg::ST_NB_RD:    state_next = nb_in ? prf_pkg::ST_NB_WR : prf_pkg::ST_NEXT;
      prf_pkg::ST_NB_WR:    state_next = prf_pkg::ST_NEXT;
      prf_pkg::ST_NEXT: begin
        if (done_all) begin
          state_next = prf_pkg::ST_DONE;
        end else if (nb_leaf && (nb_label < scan_pointer)) begin
          state_next = prf_pkg::ST_LEAF_RD;
        end else begin
          state_next = prf_pkg::ST_SCAN_RD;
        end
      end
      prf_pkg::ST_DONE:     state_next = prf_pkg::ST_IDLE;
      default:              state_next = prf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req       = '0;
    alu_op    = prf_pkg::ALU_INC;
    alu_cur   = rd_data;
    alu_other = '0;
    out_load  = 1'b0;
    unique case (state)
      prf_pkg::ST_A_RD: begin
        req.rd_en   = prf_pkg::in_store(edge_a);
        req.rd_addr = prf_pkg::label_index(edge_a);
      end
      prf_pkg::ST_A_WR: begin
        alu_other   = edge_b;
        req.wr_en   = 1'b1;
        req.wr_addr = prf_pkg::label_index(edge_a);
      end
      prf_pkg::ST_B_RD: begin
        req.rd_en   = prf_pkg::in_store(edge_b);
        req.rd_addr = prf_pkg::label_index(edge_b);
      end
      prf_pkg::ST_B_WR: begin
        alu_other   = edge_a;
        req.wr_en   = 1'b1;
        req.wr_addr = prf_pkg::label_index(edge_b);
      end
      prf_pkg::ST_SCAN_RD: begin
        req.rd_en   = (scan_pointer <= eff_n);
        req.rd_addr = prf_pkg::label_index(scan_pointer);
      end
      prf_pkg::ST_LEAF_RD: begin
        req.rd_en   = leaf_in;
        req.rd_addr = prf_pkg::label_index(current_leaf);
      end
      prf_pkg::ST_LEAF_CK: begin
        alu_op      = prf_pkg::ALU_DEC;
        out_load    = slot_free;
        req.wr_en   = slot_free && leaf_in;
        req.wr_addr = prf_pkg::label_index(current_leaf);
      end
      prf_pkg::ST_NB_RD: begin
        req.rd_en   = nb_in;
        req.rd_addr = prf_pkg::label_index(nb_label);
      end
      prf_pkg::ST_NB_WR: begin
        alu_op      = prf_pkg::ALU_DEC;
        alu_other   = current_leaf;
        req.wr_en   = 1'b1;
        req.wr_addr = prf_pkg::label_index(nb_label);
      end
      prf_pkg::ST_DONE: begin
        req.clear   = 1'b1;
      end
      default: begin
      end
    endcase
    req.wr_data = alu_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_pointer  <= prf_pkg::LABEL_W'(1);
      current_leaf  <= '0;
      emitted_count <= '0;
      nb_leaf       <= 1'b0;
    end else begin
      unique case (state)
        prf_pkg::ST_EDGE_END: begin
          scan_pointer  <= prf_pkg::LABEL_W'(1);
          emitted_count <= '0;
        end
        prf_pkg::ST_SCAN_RD: begin
          if (scan_pointer > eff_n) begin
            current_leaf <= scan_pointer;
          end
        end
        prf_pkg::ST_SCAN_CK: begin
          if (rd_data.degree == prf_pkg::DEG_W'(1)) begin
            current_leaf <= scan_pointer;
          end else begin
            scan_pointer <= scan_pointer + prf_pkg::LABEL_W'(1);
          end
        end
        prf_pkg::ST_LEAF_CK: begin
          if (slot_free) begin
            emitted_count <= emitted_count + prf_pkg::COUNT_W'(1);
          end
        end
        prf_pkg::ST_NB_RD: begin
          if (!nb_in) begin
            nb_leaf <= 1'b0;
          end
        end
        prf_pkg::ST_NB_WR: begin
          nb_leaf <= (alu_res.degree == prf_pkg::DEG_W'(1));
        end
        prf_pkg::ST_NEXT: begin
          if (!done_all) begin
            if (nb_leaf && (nb_label < scan_pointer)) begin
              current_leaf <= nb_label;
            end else if (scan_pointer <= eff_n) begin
              scan_pointer <= scan_pointer + prf_pkg::LABEL_W'(1);
            end
          end
        end
        prf_pkg::ST_DONE: begin
          scan_pointer  <= prf_pkg::LABEL_W'(1);
          current_leaf  <= '0;
          emitted_count <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == prf_pkg::ST_IDLE) && in_valid) begin
      edge_a    <= end_a;
      edge_b    <= end_b;
      edge_last <= last_edge;
    end
    if ((state == prf_pkg::ST_LEAF_CK) && slot_free) begin
      nb_label <= leaf_nb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      code_node <= leaf_nb;
      last_code <= ({1'b0, emitted_count} + prf_pkg::LABEL_W'(1) == total);
    end
  end

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    scan_pointer <= eff_n + prf_pkg::LABEL_W'(1))
    else $error("scan pointer ran past node count");

  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == prf_pkg::ST_LEAF_CK) |-> ({1'b0, emitted_count} < total))
    else $error("more codes than node count allows");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("code loaded over a pending request");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int ITEMS  = 410;
  localparam int SETTLE = 600;

  typedef struct packed {
    prf_pkg::label_t a;
    prf_pkg::label_t b;
    logic            last;
  } edge_req_t;

  typedef struct packed {
    prf_pkg::label_t node;
    logic            last;
  } prufer_code_t;

  logic                        clk;
  logic                        rst = 1'b1;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [prf_pkg::PADDR_W-1:0] paddr = '0;
  logic [prf_pkg::DATA_W-1:0]  pwdata = '0;
  logic [prf_pkg::DATA_W-1:0]  prdata;
  logic                        pready;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  prf_pkg::label_t             end_a = '0;
  prf_pkg::label_t             end_b = '0;
  logic                        last_edge = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  prf_pkg::label_t             code_node;
  logic                        last_code;

  tree_to_prufer_encoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .end_a     (end_a),
    .end_b     (end_b),
    .last_edge (last_edge),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .code_node (code_node),
    .last_code (last_code)
  );

  edge_req_t    edge_q[$];
  prufer_code_t code_q[$];
  edge_req_t    cur;

  logic [6:0]      deg_tab [prf_pkg::MAX_NODES];
  prf_pkg::label_t nbr_tab [prf_pkg::MAX_NODES];
  logic [6:0]      count_reg = 7'd64;

  int  queued_cnt = 0;
  int  taken_cnt = 0;
  int  seq_cnt = 0;
  int  checked_cnt = 0;
  int  settings_cnt = 0;
  int  errors = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_req = 0;
  bit  idle_on = 1;
  bit  in_took = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

  task automatic note_mismatch(string what, int got, int want);
    errors++;
    if (errors <= 40) $display("mismatch %s: got %0d, want %0d", what, got, want);
  endtask

  function automatic void clear_tables();
    for (int i = 0; i < prf_pkg::MAX_NODES; i++) begin
      deg_tab[i] = '0;
      nbr_tab[i] = '0;
    end
  endfunction

  function automatic int degree_at(int lab, int n);
    return (lab >= 1 && lab <= n) ? int'(deg_tab[lab-1]) : 0;
  endfunction

  function automatic int neighbour_at(int lab, int n);
    return (lab >= 1 && lab <= n) ? int'(nbr_tab[lab-1]) : 0;
  endfunction

  function automatic void tally_end(prf_pkg::label_t lab, prf_pkg::label_t other);
    if (lab != '0 && lab <= prf_pkg::MAX_NODES) begin
      deg_tab[lab-1] = deg_tab[lab-1] + 7'd1;
      nbr_tab[lab-1] = nbr_tab[lab-1] ^ other;
    end
  endfunction

  function automatic void encode_edge(prf_pkg::label_t a, prf_pkg::label_t b, logic last);
    int n;
    int total;
    int made;
    int ptr;
    int leaf;
    int nb;
    prufer_code_t c;
    tally_end(a, b);
    tally_end(b, a);
    if (last) begin
      n = (count_reg > prf_pkg::MAX_NODES) ? prf_pkg::MAX_NODES : int'(count_reg);
      if (n > 2) begin
        total = n - 2;
        ptr = 1;
        while (ptr <= n && degree_at(ptr, n) != 1) ptr++;
        leaf = ptr;
        for (made = 0; made < total; ) begin
          nb = neighbour_at(leaf, n);
          made++;
          c.node = prf_pkg::label_t'(nb);
          c.last = (made == total);
          code_q = {code_q, c};
          if (leaf >= 1 && leaf <= n) deg_tab[leaf-1] = deg_tab[leaf-1] - 7'd1;
          if (nb >= 1 && nb <= n) begin
            deg_tab[nb-1] = deg_tab[nb-1] - 7'd1;
            nbr_tab[nb-1] = nbr_tab[nb-1] ^ prf_pkg::label_t'(leaf);
          end
          if (degree_at(nb, n) == 1 && nb < ptr) begin
            leaf = nb;
          end else begin
            if (ptr <= n) ptr++;
            while (ptr <= n && degree_at(ptr, n) != 1) ptr++;
            leaf = ptr;
          end
        end
      end
      clear_tables();
    end
  endfunction

  // monitor: sample both channels at the rising edge
  always @(posedge clk) begin
    prufer_code_t want;
    in_took = !rst && in_valid && in_ready;
    if (in_took) begin
      taken_cnt++;
      if (last_edge) seq_cnt++;
      encode_edge(end_a, end_b, last_edge);
    end
    if (!rst && out_valid && out_ready) begin
      if (code_q.size() == 0) begin
        note_mismatch("code with none pending", code_node, 0);
      end else begin
        want = code_q.pop_front();
        checked_cnt++;
        if (code_node !== want.node) note_mismatch("code_node", code_node, want.node);
        if (last_code !== want.last) note_mismatch("last_code", last_code, want.last);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst && (!in_valid || in_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (edge_q.size() > 0) begin
        cur = edge_q.pop_front();
        in_valid  <= 1'b1;
        end_a     <= cur.a;
        end_b     <= cur.b;
        last_edge <= cur.last;
        if (idle_on && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 5);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 0;
      hold_left = 299;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!rst && idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= !rst;
    end
  end

  task automatic put_edge(int a, int b, bit last);
    edge_req_t r;
    r.a = prf_pkg::label_t'(a);
    r.b = prf_pkg::label_t'(b);
    r.last = last;
    edge_q = {edge_q, r};
    queued_cnt++;
  endtask

  task automatic drain(int settle);
    do @(negedge clk); while (taken_cnt != queued_cnt || code_q.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  task automatic set_node_count(logic [6:0] v);
    logic [prf_pkg::DATA_W-1:0] got;
    drain(SETTLE);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {prf_pkg::REG_NODE_COUNT, 2'b00};
    pwdata  <= {25'($urandom), v};
    @(negedge clk) penable <= 1'b1;
    @(negedge clk) begin
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end
    @(negedge clk) penable <= 1'b1;
    @(posedge clk) got = prdata;
    @(negedge clk) begin
      psel    <= 1'b0;
      penable <= 1'b0;
    end
    count_reg = v;
    settings_cnt++;
    if (got[6:0] !== v) note_mismatch("node_count readback", got[6:0], v);
  endtask

  // random labelled tree, part path and part bushy, edges and ends shuffled
  task automatic queue_tree(int n, bit mangle);
    int lab [prf_pkg::MAX_NODES];
    int ea [prf_pkg::MAX_NODES];
    int eb [prf_pkg::MAX_NODES];
    int i;
    int j;
    int t;
    int k;
    for (i = 0; i < n; i++) lab[i] = i + 1;
    for (i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = lab[i];
      lab[i] = lab[j];
      lab[j] = t;
    end
    for (i = 1; i < n; i++) begin
      ea[i-1] = lab[i];
      eb[i-1] = $urandom_range(0, 1) ? lab[i-1] : lab[$urandom_range(0, i - 1)];
      if ($urandom_range(0, 1)) begin
        t = ea[i-1];
        ea[i-1] = eb[i-1];
        eb[i-1] = t;
      end
    end
    for (i = n - 2; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = ea[i];
      ea[i] = ea[j];
      ea[j] = t;
      t = eb[i];
      eb[i] = eb[j];
      eb[j] = t;
    end
    if (mangle) begin
      k = $urandom_range(0, n - 2);
      if ($urandom_range(0, 1)) ea[k] = $urandom_range(0, 127);
      else eb[k] = $urandom_range(0, 127);
    end
    for (i = 0; i < n - 1; i++) put_edge(ea[i], eb[i], i == n - 2);
  endtask

  task automatic queue_noise(int n);
    int k;
    int hi;
    hi = (n < 1) ? 1 : n;
    k = $urandom_range(1, 6);
    for (int i = 0; i < k; i++) begin
      if ($urandom_range(0, 1)) put_edge($urandom_range(1, hi), $urandom_range(1, hi), i == k - 1);
      else put_edge($urandom_range(0, 127), $urandom_range(0, 127), i == k - 1);
    end
  endtask

  initial begin
    int  phase;
    int  cnt;
    int  neff;
    int  budget;
    int  pick;
    int  i;
    bit  first;
    clear_tables();
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // reset node count: one edge, scan runs off the end for the rest
    put_edge(1, 2, 1);
    set_node_count(7'd3);
    put_edge(1, 2, 0);
    put_edge(3, 2, 1);
    set_node_count(7'd2);
    put_edge(2, 1, 1);
    set_node_count(7'd0);
    put_edge(127, 0, 1);
    set_node_count(7'd1);
    put_edge(64, 64, 1);
    set_node_count(7'd4);
    put_edge(0, 3, 0);
    put_edge(100, 2, 0);
    put_edge(4, 1, 0);
    put_edge(1, 2, 0);
    put_edge(2, 3, 1);
    set_node_count(7'd6);
    put_edge(9, 1, 0);
    put_edge(1, 2, 0);
    put_edge(2, 6, 0);
    put_edge(6, 64, 1);
    set_node_count(7'd5);
    put_edge(5, 1, 0);
    put_edge(5, 2, 0);
    put_edge(5, 3, 0);
    put_edge(4, 5, 1);

    phase = 0;
    while (queued_cnt < ITEMS) begin
      case (phase)
        0: cnt = 127;
        1: cnt = $urandom_range(6, 12);
        2: cnt = $urandom_range(3, 8);
        3: cnt = 8;
        4: cnt = 64;
        default: cnt = $urandom_range(3, 24);
      endcase
      set_node_count(7'(cnt));
      if (queued_cnt >= ITEMS - 50) idle_on = 0;
      neff = (cnt > prf_pkg::MAX_NODES) ? prf_pkg::MAX_NODES : cnt;
      if (phase == 3) begin
        // wrap one degree count with self loops
        pick = $urandom_range(1, neff);
        for (i = 0; i < 65; i++) put_edge(pick, pick, 0);
      end
      budget = (queued_cnt + 35 < ITEMS) ? queued_cnt + 35 : ITEMS;
      first = 1;
      while (queued_cnt < budget) begin
        pick = $urandom_range(0, 9);
        if (neff < 2 || pick == 0) queue_noise(neff);
        else queue_tree(neff, pick == 1);
        if (first && phase == 1) hold_req = 1;
        if (first && phase == 2) drain(0);
        first = 0;
      end
      phase++;
    end

    for (i = 0; i < 1_000_000 && (taken_cnt != queued_cnt || code_q.size() != 0); i++)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (code_q.size() != 0) note_mismatch("codes never produced", code_q.size(), 0);
    $display("run: %0d edge requests in %0d sequences over %0d node-count writes",
             taken_cnt, seq_cnt, settings_cnt);
    $display("run: %0d codes compared, %0d mismatches", checked_cnt, errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/prf_pkg.sv
rtl/prf_ram.sv
rtl/prf_store.sv
rtl/prf_alu.sv
rtl/tree_to_prufer_encoder_unit.sv
tb/tb.sv
